// ===== design/gmda_pkg.sv =====
`default_nettype none
package gmda_pkg;

   localparam logic [7:0] HOLD_POLLS = 8'd200;
   localparam int CSR_INDEX_W = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_AF_LIMIT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AF_RELEASE = 1'b1;

   localparam logic [7:0] AF_LIMIT_RESET   = 8'd7;
   localparam logic [7:0] AF_RELEASE_RESET = 8'd4;

   typedef struct packed {
      logic [5:0] phase0_lines;
      logic [5:0] phase1_lines;
      logic [3:0] phase5_lines;
      logic [3:0] phase6_lines;
      logic       host_mode_pin;
   } item_type;

   typedef struct packed {
      logic [7:0] autofire_limit;
      logic [7:0] autofire_release;
   } cfg_type;

   typedef struct packed {
      logic       was_three_button;
      logic       two_button_seen;
      logic       paddle_on;
      logic       a_acts_as_up;
      logic [7:0] start_hold_count;
      logic [7:0] af_x;
      logic [7:0] af_y;
      logic [7:0] af_z;
   } pad_state_type;

   typedef struct packed {
      logic       paddle_mode;
      logic [7:0] port_tristate;
      logic [1:0] port_latch_buttons;
      logic [7:0] paddle_tristate_hold;
   } result_type;

endpackage
`default_nettype wire

// ===== design/gamepad_mux_decode_autofire_unit.sv =====
// multiplexed gamepad poll decoder with autofire and paddle emulation
//
// request channel: req_valid/req_ready carry one poll (line samples of select
// phases 0, 1, 5, 6 and the host mode pin). response channel: rsp_valid/
// rsp_ready carry the port tristate word, latch bits, paddle flag and the
// paddle hold word for that poll, one response per request, in order.
// csr_write with csr_index 0 sets the autofire limit, index 1 the release
// point; write only while no request is in flight.
//
// the request is registered in the input register, then decoded into the
// response register, where rsp_valid rises. throughput: one request per
// cycle while the receiver keeps taking responses; the decode is a single
// short combinational pass.
// reset clears the pad state, the autofire counters and both pipeline
// valids, and restores limit 7 and release 4.
// when the receiver stalls, the response register holds, the input register
// keeps its request, and req_ready drops once both are full.
`default_nettype none
module gamepad_mux_decode_autofire_unit import gmda_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [5:0]             req_phase0_lines,
   input  wire logic [5:0]             req_phase1_lines,
   input  wire logic [3:0]             req_phase5_lines,
   input  wire logic [3:0]             req_phase6_lines,
   input  wire logic                   req_host_mode_pin,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_paddle_mode,
   output logic [7:0]                  rsp_port_tristate,
   output logic [1:0]                  rsp_port_latch_buttons,
   output logic [7:0]                  rsp_paddle_tristate_hold,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata
);

   // input stage
   logic          s1_valid_ff, s1_valid_in;
   item_type      s1_item_ff;
   // pad state and configuration
   pad_state_type st_ff, st_next;
   cfg_type       cfg_ff;
   // response stage
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, result;

   logic out_free, advance, take;

   // response slot frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign take      = req_valid && req_ready;

   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   gmda_decode u_decode (
      .item    (s1_item_ff),
      .st      (st_ff),
      .cfg     (cfg_ff),
      .st_next (st_next),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // pad state moves only when a poll is decoded into the response slot
         if (advance) st_ff <= st_next;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.autofire_limit   <= AF_LIMIT_RESET;
         cfg_ff.autofire_release <= AF_RELEASE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AF_LIMIT:   cfg_ff.autofire_limit   <= csr_wdata;
            CSR_AF_RELEASE: cfg_ff.autofire_release <= csr_wdata;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff.phase0_lines  <= req_phase0_lines;
         s1_item_ff.phase1_lines  <= req_phase1_lines;
         s1_item_ff.phase5_lines  <= req_phase5_lines;
         s1_item_ff.phase6_lines  <= req_phase6_lines;
         s1_item_ff.host_mode_pin <= req_host_mode_pin;
      end
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_paddle_mode          = rsp_ff.paddle_mode;
   assign rsp_port_tristate        = rsp_ff.port_tristate;
   assign rsp_port_latch_buttons   = rsp_ff.port_latch_buttons;
   assign rsp_paddle_tristate_hold = rsp_ff.paddle_tristate_hold;

   // hold timer saturates just past the toggle point
   a_hold_sat: assert property (@(posedge clock) disable iff (reset)
      st_ff.start_hold_count <= (HOLD_POLLS + 8'd1))
      else $error("start hold count past saturation");

   // normal mode never drives a paddle hold word
   a_hold_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.paddle_mode |-> rsp_ff.paddle_tristate_hold == 8'd0)
      else $error("paddle hold word in normal mode");

   // paddle mode keeps both button latches high
   a_paddle_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.paddle_mode |-> rsp_ff.port_latch_buttons == 2'b11)
      else $error("latch not released in paddle mode");

   // both stages full and stalled: no request may be taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline full");

   // a decoded poll always lands in the response slot next cycle
   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("decoded poll lost");

endmodule
`default_nettype wire

// ===== design/gmda_decode.sv =====
`default_nettype none
module gmda_decode import gmda_pkg::*; (
   input  item_type      item,
   input  pad_state_type st,
   input  cfg_type       cfg,
   output pad_state_type st_next,
   output result_type    result
);

   function automatic logic [7:0] next_count(input logic [7:0] c, input logic released,
                                             input logic [7:0] limit);
      logic [8:0] n;
      n = {1'b0, c} + 9'd1;
      if (n > {1'b0, limit} || released) begin
         next_count = 8'd0;
      end else begin
         next_count = n[7:0];
      end
   endfunction

   logic up, down, left, right, c, b, a, start, x, y, z, mode;
   logic three;
   logic [7:0] cnt_base;
   logic t0, t1, t7, b1, b2, b3, u;
   logic [7:0] tris, hold;
   logic [1:0] latch;

   always_comb begin
      st_next = st;
      up    = item.phase0_lines[0];
      down  = item.phase0_lines[1];
      left  = item.phase0_lines[2];
      right = item.phase0_lines[3];
      c     = item.phase0_lines[4];
      b     = item.phase0_lines[5];
      three = ~item.phase1_lines[2] & ~item.phase1_lines[3];
      a     = three ? item.phase1_lines[5] : 1'b1;
      start = three ? item.phase1_lines[4] : 1'b1;
      if (item.phase5_lines == 4'd0) begin
         z    = item.phase6_lines[0];
         y    = item.phase6_lines[1];
         x    = item.phase6_lines[2];
         mode = item.phase6_lines[3];
      end else begin
         z = 1'b1; y = 1'b1; x = 1'b1; mode = 1'b1;
      end

      // pad type tracking
      if (three) st_next.two_button_seen = 1'b1;
      if (st.was_three_button && !three) st_next.two_button_seen = 1'b0;
      if (!c) st_next.two_button_seen = 1'b1;
      st_next.was_three_button = three;

      // start combos and hold timer
      cnt_base = st.start_hold_count;
      if (!start) begin
         if (!mode && !(z && c)) begin
            st_next.paddle_on = z;
            mode = 1'b1; start = 1'b1; z = 1'b1; c = 1'b1;
            cnt_base = 8'd0;
         end
         st_next.start_hold_count = cnt_base;
         if (!st_next.paddle_on) begin
            if (cnt_base < HOLD_POLLS) begin
               st_next.start_hold_count = cnt_base + 8'd1;
            end else if (cnt_base == HOLD_POLLS) begin
               st_next.a_acts_as_up     = ~st.a_acts_as_up;
               st_next.start_hold_count = cnt_base + 8'd1;
            end else begin
               start = 1'b1;
            end
         end
      end else begin
         st_next.start_hold_count = 8'd0;
      end

      st_next.af_x = next_count(st.af_x, x, cfg.autofire_limit);
      st_next.af_y = next_count(st.af_y, y, cfg.autofire_limit);
      st_next.af_z = next_count(st.af_z, z, cfg.autofire_limit);

      t0 = 1'b0; t1 = 1'b0; t7 = 1'b1;
      b1 = 1'b1; b2 = 1'b1; b3 = 1'b1; u = up;
      if (st_next.paddle_on) begin
         if (!start) begin
            t0 = 1'b1; t1 = 1'b1;
         end else if (!mode) begin
            t0 = 1'b1; t1 = 1'b0;
         end else if (!x) begin
            t0 = 1'b0; t1 = 1'b1;
         end else if (!y) begin
            t0 = 1'b0; t1 = 1'b0;
         end else begin
            t7 = 1'b0; t0 = ~a; t1 = ~b;
         end
         tris  = {t7, ~c, 1'b1, 1'b0, ~z, 1'b0, t1, t0};
         hold  = tris | {3'b000, left, 1'b0, up, 2'b00};
         tris  = tris | {3'b000, ~right, 1'b0, ~down, 2'b00};
         latch = 2'b11;
      end else begin
         b1 = b & start;
         b2 = c;
         if (!y) b1 = b1 & (st_next.af_y >= cfg.autofire_release);
         if (!z) b2 = b2 & (st_next.af_z >= cfg.autofire_release);
         if (st.a_acts_as_up ^ (st_next.a_acts_as_up ^ st.a_acts_as_up)) begin
            u  = up & a;
            b3 = 1'b1;
         end else begin
            b3 = a;
         end
         if (!x) b3 = b3 & (st_next.af_x >= cfg.autofire_release);
         tris = {left, right, 1'b1, 1'b0, b1, 1'b0, u, down};
         if (!item.host_mode_pin) begin
            latch = 2'b11;
            tris  = tris | {3'b000, b2, 1'b0, b3, 2'b00};
         end else begin
            latch = {b2, b3};
            tris  = tris | {3'b000, ~st_next.two_button_seen, 1'b0, ~three, 2'b00};
         end
         hold = 8'd0;
      end

      result.paddle_mode          = st_next.paddle_on;
      result.port_tristate        = tris;
      result.port_latch_buttons   = latch;
      result.paddle_tristate_hold = hold;
   end

endmodule
`default_nettype wire

// ===== tb/gamepad_mux_decode_autofire_unit_tb.sv =====
`timescale 1ns / 1ps
module gamepad_mux_decode_autofire_unit_tb;
   import gmda_pkg::*;

   // pad flavors for the random poll generator
   typedef enum int {PAD_TWO, PAD_THREE, PAD_SIX} pad_kind_type;

   // buttons held on the emulated pad, 1 = pressed
   typedef struct packed {
      logic mode, z, y, x, start, c, b, a, right, left, down, up;
   } pad_buttons_type;

   // idle three-button phase 1 sample: marker bits low, nothing pressed
   localparam logic [5:0] P1_THREE_IDLE  = 6'b110011;
   localparam logic [5:0] P1_THREE_START = 6'b100011;
   localparam logic [5:0] LINES6_IDLE    = 6'h3F;
   localparam logic [3:0] LINES4_IDLE    = 4'hF;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [5:0]             req_phase0_lines;
   logic [5:0]             req_phase1_lines;
   logic [3:0]             req_phase5_lines;
   logic [3:0]             req_phase6_lines;
   logic                   req_host_mode_pin;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_paddle_mode;
   logic [7:0]             rsp_port_tristate;
   logic [1:0]             rsp_port_latch_buttons;
   logic [7:0]             rsp_paddle_tristate_hold;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   gamepad_mux_decode_autofire_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_phase0_lines        (req_phase0_lines),
      .req_phase1_lines        (req_phase1_lines),
      .req_phase5_lines        (req_phase5_lines),
      .req_phase6_lines        (req_phase6_lines),
      .req_host_mode_pin       (req_host_mode_pin),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_paddle_mode         (rsp_paddle_mode),
      .rsp_port_tristate       (rsp_port_tristate),
      .rsp_port_latch_buttons  (rsp_port_latch_buttons),
      .rsp_paddle_tristate_hold(rsp_paddle_tristate_hold),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   // expected port words, oldest first
   result_type port_word_q[$];
   int         errors = 0;

   // shadow of the pad decoder state and its autofire settings
   logic [7:0] af_limit;
   logic [7:0] af_rel_point;
   logic       sh_was_three;
   logic       sh_two_seen;
   logic       sh_paddle;
   logic       sh_a_up;
   logic [7:0] sh_hold_cnt;
   logic [7:0] sh_af [3];

   // random pad generator state
   pad_kind_type    gen_kind = PAD_THREE;
   pad_buttons_type gen_held = '0;
   logic            gen_host = 1'b1;
   int              gen_start_left = 0;
   int              gen_flip_odds = 16;

   // pacing state for both sides
   int   req_steady_left = 0;
   int   rdy_left = 0;
   logic rdy_level = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the response stream stalls for good
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // autofire counter step: wraps past the limit, clears when released
   function automatic logic [7:0] next_af(logic [7:0] cnt, logic released);
      int n;
      n = int'(cnt);
      n = n + 1;
      if (n > int'(af_limit) || released)
         return 8'd0;
      return n[7:0];
   endfunction

   // decodes one poll and advances the shadow state
   function automatic result_type decode_poll(item_type it);
      logic       up, down, left, right, c, b;
      logic       a, start, x, y, z, mode, three;
      logic       t0, t1, t7, b1, b2, b3, u;
      logic [7:0] tris, hold;
      logic [1:0] latch;
      result_type r;
      up    = it.phase0_lines[0];
      down  = it.phase0_lines[1];
      left  = it.phase0_lines[2];
      right = it.phase0_lines[3];
      c     = it.phase0_lines[4];
      b     = it.phase0_lines[5];
      a = 1'b1; start = 1'b1; x = 1'b1; y = 1'b1; z = 1'b1; mode = 1'b1;
      three = 1'b0;

      // both horizontal lines low in phase 1 mark a three-button pad
      if (!it.phase1_lines[2] && !it.phase1_lines[3]) begin
         three       = 1'b1;
         sh_two_seen = 1'b1;
         a           = it.phase1_lines[5];
         start       = it.phase1_lines[4];
      end
      // all directions low in phase 5 announce the extra buttons
      if (it.phase5_lines == 4'd0) begin
         z    = it.phase6_lines[0];
         y    = it.phase6_lines[1];
         x    = it.phase6_lines[2];
         mode = it.phase6_lines[3];
      end
      if (sh_was_three && !three)
         sh_two_seen = 1'b0;
      if (!c)
         sh_two_seen = 1'b1;
      sh_was_three = three;

      if (!start) begin
         // start+mode with c turns paddle on, with z turns it off
         if (!mode && !(z && c)) begin
            sh_paddle   = z;
            mode        = 1'b1;
            start       = 1'b1;
            z           = 1'b1;
            c           = 1'b1;
            sh_hold_cnt = 8'd0;
         end
         if (!sh_paddle) begin
            if (sh_hold_cnt < HOLD_POLLS) begin
               sh_hold_cnt = sh_hold_cnt + 8'd1;
            end else if (sh_hold_cnt == HOLD_POLLS) begin
               sh_a_up     = ~sh_a_up;
               sh_hold_cnt = sh_hold_cnt + 8'd1;
            end else begin
               // start masked until let go
               start = 1'b1;
            end
         end
      end else begin
         sh_hold_cnt = 8'd0;
      end

      sh_af[0] = next_af(sh_af[0], x);
      sh_af[1] = next_af(sh_af[1], y);
      sh_af[2] = next_af(sh_af[2], z);

      if (sh_paddle) begin
         t7 = 1'b1;
         if (!start) begin
            t0 = 1'b1; t1 = 1'b1;
         end else if (!mode) begin
            t0 = 1'b1; t1 = 1'b0;
         end else if (!x) begin
            t0 = 1'b0; t1 = 1'b1;
         end else if (!y) begin
            t0 = 1'b0; t1 = 1'b0;
         end else begin
            t7 = 1'b0; t0 = ~a; t1 = ~b;
         end
         tris = {t7, ~c, 1'b1, 1'b0, ~z, 1'b0, t1, t0};
         hold = tris;
         hold[2] = hold[2] | up;
         hold[4] = hold[4] | left;
         tris[2] = tris[2] | ~down;
         tris[4] = tris[4] | ~right;
         latch = 2'b11;
      end else begin
         b1 = b & start;
         b2 = c;
         u  = up;
         if (!y)
            b1 = b1 & (sh_af[1] >= af_rel_point);
         if (!z)
            b2 = b2 & (sh_af[2] >= af_rel_point);
         if (sh_a_up) begin
            u  = u & a;
            b3 = 1'b1;
         end else begin
            b3 = a;
         end
         if (!x)
            b3 = b3 & (sh_af[0] >= af_rel_point);
         tris = {left, right, 1'b1, 1'b0, b1, 1'b0, u, down};
         if (!it.host_mode_pin) begin
            latch   = 2'b11;
            tris[2] = b3;
            tris[4] = b2;
         end else begin
            latch   = {b2, b3};
            tris[2] = ~three;
            tris[4] = ~sh_two_seen;
         end
         hold = 8'd0;
      end

      r.paddle_mode          = sh_paddle;
      r.port_tristate        = tris;
      r.port_latch_buttons   = latch;
      r.paddle_tristate_hold = hold;
      return r;
   endfunction

   function automatic item_type pad_poll(logic [5:0] p0, logic [5:0] p1,
                                         logic [3:0] p5, logic [3:0] p6,
                                         logic host);
      item_type it;
      it.phase0_lines  = p0;
      it.phase1_lines  = p1;
      it.phase5_lines  = p5;
      it.phase6_lines  = p6;
      it.host_mode_pin = host;
      return it;
   endfunction

   // mostly short gaps, a few long ones, now and then a gapless burst
   function automatic int pick_req_gap();
      int r;
      if (req_steady_left > 0) begin
         req_steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         req_steady_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // well-formed pad polls with sticky buttons, plus some line noise
   function automatic item_type random_poll();
      item_type        it;
      pad_buttons_type h;
      logic [11:0]     flip;
      if ($urandom_range(0, 99) < 8) begin
         it.phase0_lines  = 6'($urandom_range(0, 63));
         it.phase1_lines  = 6'($urandom_range(0, 63));
         it.phase5_lines  = 4'($urandom_range(0, 15));
         it.phase6_lines  = 4'($urandom_range(0, 15));
         it.host_mode_pin = 1'($urandom_range(0, 1));
         return it;
      end
      if ($urandom_range(0, 49) == 0)
         gen_kind = pad_kind_type'($urandom_range(0, 2));
      if ($urandom_range(0, 19) == 0)
         gen_host = ~gen_host;
      for (int i = 0; i < 12; i++)
         flip[i] = ($urandom_range(1, gen_flip_odds) == 1);
      gen_held = gen_held ^ flip;
      h = gen_held;
      // occasional long start hold to walk the hold timer
      if (gen_start_left > 0) begin
         gen_start_left--;
         h.start = 1'b1;
         h.mode  = 1'b0;
      end else if ($urandom_range(0, 399) == 0) begin
         gen_start_left = $urandom_range(195, 210);
      end
      it.phase0_lines = ~{h.b, h.c, h.right, h.left, h.down, h.up};
      if (gen_kind == PAD_TWO)
         it.phase1_lines = it.phase0_lines;
      else
         it.phase1_lines = ~{h.a, h.start, 1'b1, 1'b1, h.down, h.up};
      if (gen_kind == PAD_SIX) begin
         it.phase5_lines = 4'd0;
         it.phase6_lines = ~{h.mode, h.x, h.y, h.z};
      end else begin
         it.phase5_lines = ~{h.right, h.left, h.down, h.up};
         it.phase6_lines = 4'($urandom_range(0, 15));
      end
      it.host_mode_pin = gen_host;
      return it;
   endfunction

   // offer one poll, hold it until taken, then queue its expected word
   task automatic send_poll(item_type it);
      int gap;
      gap = pick_req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_phase0_lines  <= it.phase0_lines;
      req_phase1_lines  <= it.phase1_lines;
      req_phase5_lines  <= it.phase5_lines;
      req_phase6_lines  <= it.phase6_lines;
      req_host_mode_pin <= it.host_mode_pin;
      do @(posedge clock); while (!req_ready);
      port_word_q.push_back(decode_poll(it));
   endtask

   // stop sending and let every outstanding request come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (port_word_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both autofire registers, written back to back while idle
   task automatic set_autofire(logic [7:0] limit, logic [7:0] rel);
      csr_write <= 1'b1;
      csr_index <= CSR_AF_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= CSR_AF_RELEASE;
      csr_wdata <= rel;
      @(posedge clock);
      csr_write <= 1'b0;
      af_limit     = limit;
      af_rel_point = rel;
      @(posedge clock);
   endtask

   task automatic note_mismatch(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40)
         $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
   endtask

   // field extremes, pad flavors, host pin, paddle on/off combos
   task automatic test_directed_decode();
      send_poll(pad_poll(LINES6_IDLE, LINES6_IDLE, LINES4_IDLE, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, LINES6_IDLE, LINES4_IDLE, LINES4_IDLE, 1'b0));
      // everything pressed: start+mode with c and z both down turns paddle off
      send_poll(pad_poll(6'h00, 6'h00, 4'h0, 4'h0, 1'b1));
      send_poll(pad_poll(6'h00, 6'h00, 4'h0, 4'h0, 1'b0));
      // three-button pad, directions and a/b/c
      send_poll(pad_poll(6'b111110, 6'b110010, LINES4_IDLE, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(6'b011101, 6'b010001, LINES4_IDLE, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(6'b011101, 6'b010001, LINES4_IDLE, LINES4_IDLE, 1'b0));
      send_poll(pad_poll(6'b101011, P1_THREE_IDLE, LINES4_IDLE, LINES4_IDLE, 1'b1));
      // six-button pad: x, y, z, mode one at a time
      send_poll(pad_poll(6'b110111, P1_THREE_IDLE, 4'h0, 4'b1011, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_IDLE, 4'h0, 4'b1101, 1'b0));
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_IDLE, 4'h0, 4'b1110, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_IDLE, 4'h0, 4'b0111, 1'b1));
      // start+mode+c: paddle on
      send_poll(pad_poll(6'b101111, P1_THREE_START, 4'h0, 4'b0111, 1'b1));
      // paddle words: start, mode, x, y, then a/b and the direction pins
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_START, 4'h0, 4'b0111, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_IDLE, 4'h0, 4'b0111, 1'b1));
      send_poll(pad_poll(6'b111010, P1_THREE_IDLE, 4'h0, 4'b1011, 1'b1));
      send_poll(pad_poll(6'b110101, P1_THREE_IDLE, 4'h0, 4'b1101, 1'b0));
      send_poll(pad_poll(6'b011111, 6'b010011, 4'h0, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(6'b101111, P1_THREE_IDLE, 4'h0, 4'b1110, 1'b1));
      // start+mode+z: paddle off, hold timer restarts at one
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_START, 4'h0, 4'b0110, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_START, LINES4_IDLE, LINES4_IDLE, 1'b1));
      // back to a two-button read clears the seen flag, c sets it again
      send_poll(pad_poll(LINES6_IDLE, LINES6_IDLE, LINES4_IDLE, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(6'b101111, LINES6_IDLE, LINES4_IDLE, LINES4_IDLE, 1'b1));
   endtask

   // start held past the hold limit flips a-as-up, then reads released
   task automatic test_start_hold();
      repeat (203)
         send_poll(pad_poll(LINES6_IDLE, P1_THREE_START, LINES4_IDLE, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, P1_THREE_IDLE, LINES4_IDLE, LINES4_IDLE, 1'b1));
      // second hold with a pressed flips it back
      repeat (203)
         send_poll(pad_poll(LINES6_IDLE, 6'b000011, LINES4_IDLE, LINES4_IDLE, 1'b1));
      send_poll(pad_poll(LINES6_IDLE, 6'b010011, LINES4_IDLE, LINES4_IDLE, 1'b0));
   endtask

   // one autofire setting, then a stream of random polls
   task automatic test_random_polls(logic [7:0] limit, logic [7:0] rel, int count,
                                    int flip_odds);
      drain_responses();
      set_autofire(limit, rel);
      gen_flip_odds = flip_odds;
      repeat (count)
         send_poll(random_poll());
   endtask

   // receiver pacing: short and long stalls, with stall-free stretches
   always @(posedge clock) begin
      int r;
      if (rdy_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rdy_level = 1'b1;
            rdy_left  = $urandom_range(1, 8);
         end else if (r < 60) begin
            rdy_level = 1'b1;
            rdy_left  = $urandom_range(30, 120);
         end else if (r < 92) begin
            rdy_level = 1'b0;
            rdy_left  = $urandom_range(1, 3);
         end else begin
            rdy_level = 1'b0;
            rdy_left  = $urandom_range(10, 40);
         end
      end else begin
         rdy_left--;
      end
      rsp_ready <= rdy_level;
   end

   // response checker: each accepted word against the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (port_word_q.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t mismatch response: expected none actual %0h", $time,
                        rsp_port_tristate);
         end else begin
            want = port_word_q.pop_front();
            if (rsp_paddle_mode !== want.paddle_mode)
               note_mismatch("paddle_mode", 32'(want.paddle_mode), 32'(rsp_paddle_mode));
            if (rsp_port_tristate !== want.port_tristate)
               note_mismatch("port_tristate", 32'(want.port_tristate),
                             32'(rsp_port_tristate));
            if (rsp_port_latch_buttons !== want.port_latch_buttons)
               note_mismatch("port_latch_buttons", 32'(want.port_latch_buttons),
                             32'(rsp_port_latch_buttons));
            if (rsp_paddle_tristate_hold !== want.paddle_tristate_hold)
               note_mismatch("paddle_tristate_hold", 32'(want.paddle_tristate_hold),
                             32'(rsp_paddle_tristate_hold));
         end
      end
   end

   initial begin
      // known levels on every input before the first edge
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_phase0_lines  = LINES6_IDLE;
      req_phase1_lines  = LINES6_IDLE;
      req_phase5_lines  = LINES4_IDLE;
      req_phase6_lines  = LINES4_IDLE;
      req_host_mode_pin = 1'b1;
      rsp_ready         = 1'b0;
      csr_write         = 1'b0;
      csr_index         = CSR_AF_LIMIT;
      csr_wdata         = 8'd0;

      // shadow state matches the block after reset
      af_limit     = AF_LIMIT_RESET;
      af_rel_point = AF_RELEASE_RESET;
      sh_was_three = 1'b0;
      sh_two_seen  = 1'b0;
      sh_paddle    = 1'b0;
      sh_a_up      = 1'b0;
      sh_hold_cnt  = 8'd0;
      for (int i = 0; i < 3; i++)
         sh_af[i] = 8'd0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_decode();
      test_start_hold();
      // limit above the legal range still wraps, long button holds
      test_random_polls(8'd255, 8'd200, 300, 300);
      // limit lowered under the running counters
      test_random_polls(8'd2, 8'd1, 144, 16);
      test_random_polls(8'd0, 8'd0, 144, 8);
      test_random_polls(8'd254, 8'd255, 144, 64);
      test_random_polls(8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)), 144, 16);
      test_random_polls(AF_LIMIT_RESET, AF_RELEASE_RESET, 144, 16);
      drain_responses();

      if (errors == 0 && port_word_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
